// File: rtl/ebwv_pkg.sv
// Package: payload types and CORDIC constants for the body-to-world velocity rotation.
`default_nettype none
package ebwv_pkg;
    localparam int VelW    = 24;
    localparam int AngW    = 16;
    localparam int Steps   = 30;
    localparam int CordW   = 34;
    localparam logic signed [CordW-1:0] CordX0 = 34'sd652032874;

    typedef struct packed {
        logic signed [VelW-1:0] body_fwd_vel;
        logic signed [VelW-1:0] body_side_vel;
        logic signed [VelW-1:0] body_down_vel;
        logic signed [AngW-1:0] roll_angle;
        logic signed [AngW-1:0] pitch_angle;
        logic signed [AngW-1:0] yaw_angle;
    } t_req;

    typedef struct packed {
        logic signed [VelW-1:0] north_vel;
        logic signed [VelW-1:0] east_vel;
        logic signed [VelW-1:0] down_vel;
        logic                   saturated;
    } t_rsp;

    function automatic logic signed [CordW-1:0] atan_at(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2E; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
            15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
            21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
            24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
            27: t = 32'h00000005; 28: t = 32'h00000002; default: t = 32'h00000001;
        endcase
        return $signed({2'b00, t});
    endfunction
endpackage
`default_nettype wire

// File: rtl/euler_body_to_world_velocity_top.sv
// Top level: pipelined ZYX Euler rotation of a body velocity into the world frame.
// Usage:
//   Request channel i_valid/o_stall/i_req carries the body velocity and the
//   roll, pitch and yaw binary angles. Response channel o_valid/i_stall/o_rsp
//   returns north, east and down velocity, rounded and saturated, plus a flag
//   set when any component clipped.
//   From accept to o_valid the pipeline has an angle input register,
//   30 CORDIC stages (one micro-rotation each, three angles in parallel), a
//   Q1.15 rounding stage, two matrix product stages, three stages for the row
//   sums and one output stage with saturation. One request per cycle unless stalled.
//   The whole pipeline advances together; when i_stall is high with a result
//   on the output, every stage holds and o_stall is raised, so nothing is
//   lost or repeated. The output register is the only slot ahead of the
//   receiver, and o_stall simply mirrors the held output.
//   Reset clears all valid bits; no request is in flight afterwards.
`default_nettype none
module euler_body_to_world_velocity_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire ebwv_pkg::t_req i_req,
    output logic                o_valid,
    input  wire logic           i_stall,
    output ebwv_pkg::t_rsp      o_rsp
);
    localparam int S  = ebwv_pkg::Steps;
    localparam int W  = ebwv_pkg::CordW;
    localparam int VW = ebwv_pkg::VelW;
    localparam int AW = ebwv_pkg::AngW;
    localparam int NV = S + 8;

    logic adv;
    logic [NV-1:0] r_vld;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // velocity carried alongside
    logic signed [VW-1:0] r_v [0:S+3][0:2];

    // CORDIC pipelines: 3 angles
    logic signed [W-1:0] r_x [0:S][0:2];
    logic signed [W-1:0] r_y [0:S][0:2];
    logic signed [W-1:0] r_z [0:S][0:2];
    logic                r_f [0:S][0:2];

    logic [AW-1:0] ang [0:2];
    assign ang[0] = i_req.roll_angle;
    assign ang[1] = i_req.pitch_angle;
    assign ang[2] = i_req.yaw_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[NV-2:0], i_valid};
    end

    for (genvar k = 0; k < 3; k++) begin : g_ang
        logic [31:0] a, a2;
        logic        fl;
        always_comb begin
            a  = {ang[k], {(32-AW){1'b0}}};
            fl = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
            a2 = fl ? a + 32'h80000000 : a;
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_x[0][k] <= ebwv_pkg::CordX0;
                r_y[0][k] <= '0;
                r_z[0][k] <= W'($signed(a2));
                r_f[0][k] <= fl;
            end
        end
        for (genvar i = 0; i < S; i++) begin : g_st
            logic signed [W-1:0] xs, ys;
            assign xs = r_x[i][k] >>> i;
            assign ys = r_y[i][k] >>> i;
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_f[i+1][k] <= r_f[i][k];
                    if (!r_z[i][k][W-1]) begin
                        r_x[i+1][k] <= r_x[i][k] - ys;
                        r_y[i+1][k] <= r_y[i][k] + xs;
                        r_z[i+1][k] <= r_z[i][k] - ebwv_pkg::atan_at(i);
                    end else begin
                        r_x[i+1][k] <= r_x[i][k] + ys;
                        r_y[i+1][k] <= r_y[i][k] - xs;
                        r_z[i+1][k] <= r_z[i][k] + ebwv_pkg::atan_at(i);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_v[0][0] <= i_req.body_fwd_vel;
            r_v[0][1] <= i_req.body_side_vel;
            r_v[0][2] <= i_req.body_down_vel;
            for (int j = 0; j < S+3; j++) r_v[j+1] <= r_v[j];
        end
    end

    function automatic logic signed [15:0] q15(input logic signed [W-1:0] v);
        logic signed [W:0] r;
        r = ($signed({v[W-1], v}) + (W+1)'(16384)) >>> 15;
        if (r > 32767) return 16'sd32767;
        if (r < -32768) return -16'sd32768;
        return r[15:0];
    endfunction

    // stage: sin/cos in Q1.15 (index 0 roll,1 pitch,2 yaw)
    logic signed [15:0] r_s [0:2], r_c [0:2];
    for (genvar k = 0; k < 3; k++) begin : g_q
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_c[k] <= q15(r_f[S][k] ? -r_x[S][k] : r_x[S][k]);
                r_s[k] <= q15(r_f[S][k] ? -r_y[S][k] : r_y[S][k]);
            end
        end
    end

    // stage: two-term products
    logic signed [31:0] r_spcy, r_spsy, r_cpcy, r_cpsy, r_crsy, r_srsy, r_crcy, r_srcy;
    logic signed [31:0] r_srcp, r_crcp, r_msp;
    logic signed [15:0] r_sr1, r_cr1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_spcy <= r_s[1] * r_c[2];  r_spsy <= r_s[1] * r_s[2];
            r_cpcy <= r_c[1] * r_c[2];  r_cpsy <= r_c[1] * r_s[2];
            r_crsy <= r_c[0] * r_s[2];  r_srsy <= r_s[0] * r_s[2];
            r_crcy <= r_c[0] * r_c[2];  r_srcy <= r_s[0] * r_c[2];
            r_srcp <= r_s[0] * r_c[1];  r_crcp <= r_c[0] * r_c[1];
            r_msp  <= -(32'(r_s[1]) <<< 15);
            r_sr1 <= r_s[0];  r_cr1 <= r_c[0];
        end
    end

    function automatic logic signed [32:0] tri3(input logic signed [15:0] a,
                                                input logic signed [31:0] bc);
        logic signed [47:0] p;
        p = a * bc;
        p = (p + 48'sd16384) >>> 15;
        return p[32:0];
    endfunction

    // stage: matrix entries
    logic signed [33:0] r_m [0:2][0:2];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m[0][0] <= 34'(r_cpcy);
            r_m[0][1] <= 34'(tri3(r_sr1, r_spcy)) - 34'(r_crsy);
            r_m[0][2] <= 34'(tri3(r_cr1, r_spcy)) + 34'(r_srsy);
            r_m[1][0] <= 34'(r_cpsy);
            r_m[1][1] <= 34'(tri3(r_sr1, r_spsy)) + 34'(r_crcy);
            r_m[1][2] <= 34'(tri3(r_cr1, r_spsy)) - 34'(r_srcy);
            r_m[2][0] <= 34'(r_msp);
            r_m[2][1] <= 34'(r_srcp);
            r_m[2][2] <= 34'(r_crcp);
        end
    end

    // stages: products, then sums
    localparam int PW = 34 + VW;
    localparam int SW = PW + 2;
    logic signed [PW-1:0] r_p [0:2][0:2];
    logic signed [SW-1:0] r_sum [0:2];
    logic signed [SW-30:0] r_rnd [0:2];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) r_p[r][j] <= r_m[r][j] * r_v[S+3][j];
                r_sum[r] <= SW'(r_p[r][0]) + SW'(r_p[r][1]) + SW'(r_p[r][2]);
                r_rnd[r] <= (SW-29)'((r_sum[r] + (SW'(1) <<< 29)) >>> 30);
            end
        end
    end

    // output stage with saturation
    localparam logic signed [SW-30:0] VMax = (SW-29)'((1 <<< (VW-1)) - 1);
    localparam logic signed [SW-30:0] VMin = -VMax - (SW-29)'(1);
    logic signed [VW-1:0] sv [0:2];
    logic [2:0] sf;
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sf[r] = 1'b0;
            if (r_rnd[r] > VMax) begin sv[r] = VMax[VW-1:0]; sf[r] = 1'b1; end
            else if (r_rnd[r] < VMin) begin sv[r] = VMin[VW-1:0]; sf[r] = 1'b1; end
            else sv[r] = r_rnd[r][VW-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_rsp.north_vel <= sv[0];
            o_rsp.east_vel  <= sv[1];
            o_rsp.down_vel  <= sv[2];
            o_rsp.saturated <= |sf;
        end
    end
    assign o_valid = r_vld[NV-1];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp)) else $error("output lost");
    a_stall: assert property (@(posedge i_clk) o_stall == (o_valid && i_stall))
        else $error("stall mismatch");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld)) else $error("pipeline moved while stalled");
endmodule
`default_nettype wire
